### design/qoisd_pkg.sv
// Shared types, constants and helpers for the QOI chunk-stream decoder.
// Used by qoisd_emit and qoi_image_stream_decoder; no dependencies.
package qoisd_pkg;

  localparam int CFG_W          = 25;
  localparam int COUNT_BITS_DEF = 24;
  localparam int PIX_W          = 32;
  localparam int TBL_DEPTH      = 64;
  localparam int RUN_W          = 6;

  localparam logic [15:0] RGB555_KEEP   = 16'h7BDE;
  localparam logic [15:0] RGB555_ALPHA  = 16'h8000;
  localparam logic [7:0]  BYTE_ZERO     = 8'h00;
  localparam logic [7:0]  OP_RGB        = 8'hFE;
  localparam logic [7:0]  OP_RGBA       = 8'hFF;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
  localparam logic [7:0]  DIFF_BIAS     = 8'd254;
  localparam logic [7:0]  LUMA_G_BIAS   = 8'd224;
  localparam logic [7:0]  LUMA_RB_BIAS  = 8'd248;

  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  typedef logic [PIX_W-1:0] pixel_t;

  localparam pixel_t RESET_PIXEL = {8'h00, 8'h00, 8'h00, ALPHA_OPAQUE};

  typedef enum logic [2:0] {
    PH_OP,
    PH_LUMA,
    PH_RED,
    PH_GREEN,
    PH_BLUE,
    PH_ALPHA
  } phase_t;

  // one decoded byte's worth of output: optional slot-0 pixel, then cnt-1 repeats
  typedef struct packed {
    logic             zflag;
    pixel_t           zpix;
    pixel_t           mpix;
    logic [RUN_W-1:0] cnt;
    logic             hit;
  } emit_cmd_t;

  function automatic pixel_t pack_px(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] a);
    pack_px = {r, g, b, a};
  endfunction

  function automatic logic [5:0] hash_px(input pixel_t p);
    logic [5:0] r6;
    logic [5:0] g6;
    logic [5:0] b6;
    logic [5:0] a6;
    r6 = p[29:24];
    g6 = p[21:16];
    b6 = p[13:8];
    a6 = p[5:0];
    hash_px = r6 * 6'd3 + g6 * 6'd5 + b6 * 6'd7 + a6 * 6'd11;
  endfunction

  function automatic logic [15:0] to_rgb555(input pixel_t p);
    logic [15:0] w;
    w = {1'b0, p[31:27], p[23:19], p[15:11]};
    if (!p[7]) begin
      w = (w & RGB555_KEEP) | RGB555_ALPHA;
    end
    to_rgb555 = w;
  endfunction

endpackage

### design/qoisd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module qoisd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### design/qoisd_emit.sv
// Pixel emitter: one command slot plus the output register; expands runs.
// Depends on qoisd_pkg (emit_cmd_t, pixel_t).
module qoisd_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  qoisd_pkg::emit_cmd_t  cmd,
  output logic                  cmd_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qoisd_pkg::pixel_t     out_pixel,
  output logic                  out_run_last,
  output logic                  out_image_last
);
  import qoisd_pkg::*;

  logic             cmd_vld_r, cmd_vld_nxt;
  emit_cmd_t        cmd_r;
  logic             out_vld_r, out_vld_nxt;
  pixel_t           pix_r;
  pixel_t           mpix_r;
  logic [RUN_W-1:0] left_r;
  logic             hit_r;
  logic             out_fire;
  logic             out_load;
  logic             cmd_take;

  assign out_fire = out_vld_r & ~out_stall;
  assign out_load = ~out_vld_r | (out_fire & (left_r == '0));
  assign cmd_take = out_load & cmd_vld_r;
  assign cmd_free = ~cmd_vld_r | cmd_take;

  always_comb begin
    cmd_vld_nxt = cmd_vld_r;
    if (cmd_valid && cmd_free) begin
      cmd_vld_nxt = 1'b1;
    end else if (cmd_take) begin
      cmd_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = cmd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_free) begin
      cmd_r <= cmd;
    end
    if (cmd_take) begin
      pix_r  <= cmd_r.zflag ? cmd_r.zpix : cmd_r.mpix;
      mpix_r <= cmd_r.mpix;
      left_r <= cmd_r.cnt - RUN_W'(1);
      hit_r  <= cmd_r.hit;
    end else if (out_fire && (left_r != '0)) begin
      // advance through the run
      pix_r  <= mpix_r;
      left_r <= left_r - RUN_W'(1);
    end
  end

  assign out_valid      = out_vld_r;
  assign out_pixel      = pix_r;
  assign out_run_last   = (left_r == '0);
  assign out_image_last = (left_r == '0) & hit_r;

endmodule

### design/qoi_image_stream_decoder.sv
// Top level of the byte-serial QOI chunk-stream decoder.
// Depends on qoisd_pkg, qoisd_ram (colour table) and qoisd_emit (pixel output).
//
// Usage: feed the chunk bytes that follow the QOI header on the in_ channel,
// one transaction per byte, with in_start_of_image high on the first byte of
// each image. Each decoded pixel leaves on the out_ channel as R, G, B, A and
// an RGB555 word; out_run_last marks the last pixel caused by one byte and
// out_image_last the pixel that reaches cfg_pixel_count. Write the pixel
// count on the cfg_ channel (always ready) between images.
// Throughput: one byte per cycle while each byte yields at most one pixel
// and out_stall is low; a byte yielding n pixels holds the output until all
// n have left, and the input stalls once the command slot behind the output
// register is also full. A byte passes through the decode stage, then the
// command slot, then the output register, where its first pixel is presented.
// The colour table is a 64-entry RAM read as a byte enters the decode stage;
// per-entry valid bits clear it at reset and at image start.
// Reset: pixel count 1, pixel = opaque black, table empty, no output valid.
// When out_stall is high the output holds its pixel; decode and input
// continue until the command slot and decode stage are both occupied.
module qoi_image_stream_decoder #(
  parameter int COUNT_BITS = qoisd_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_code_byte,
  input  logic                        in_start_of_image,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_alpha,
  output logic [15:0]                 out_rgb555,
  output logic                        out_run_last,
  output logic                        out_image_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [qoisd_pkg::CFG_W-1:0] cfg_pixel_count
);
  import qoisd_pkg::*;

  localparam int LIM_W  = (COUNT_BITS + 1 < CFG_W) ? COUNT_BITS + 1 : CFG_W;
  localparam int TBL_AW = $clog2(TBL_DEPTH);

  // configuration
  logic [LIM_W-1:0] lim_r;

  // decode stage
  logic             s2_valid_r, s2_valid_nxt;
  logic [7:0]       s2_byte_r;
  logic             s2_start_r;
  logic             s2_fire;
  logic             in_fire;

  // table read capture
  logic              rd_vld_r;
  logic              rd_hit_r;
  pixel_t            rd_fwd_r;
  pixel_t            ram_rdata;
  pixel_t            tbl_px;
  logic [TBL_AW-1:0] raddr;
  logic [TBL_DEPTH-1:0] tbl_vld_r, tbl_vld_nxt;

  // decoder state
  pixel_t           cur_r, cur_nxt, cur_e;
  phase_t           phase_r, phase_nxt, phase_e;
  logic [7:0]       opb_r, opb_nxt, opb_e;
  logic             zp_r, zp_nxt, zp_e;
  logic [LIM_W-1:0] pe_r, pe_nxt, pe_e;
  logic             done_r, done_nxt, done_e;
  pixel_t           slot0_r, slot0_nxt, slot0_e;

  // decode datapath
  pixel_t            base_px;
  pixel_t            new_px;
  logic              act;
  logic              zflag;
  logic              wr_flag;
  logic [6:0]        run_k;
  logic [6:0]        zk;
  logic [LIM_W-1:0]  rem;
  logic              hit;
  logic [RUN_W-1:0]  cnt;
  logic [7:0]        c;
  logic [7:0]        r8, g8, b8, a8;
  logic [7:0]        vg;
  logic              wr_en;
  logic [TBL_AW-1:0] wr_addr;
  logic              cmd_vld;
  logic              cmd_free;
  emit_cmd_t         cmd;
  pixel_t            out_px;

  assign cfg_ready = 1'b1;
  assign in_stall  = s2_valid_r & ~cmd_free;
  assign in_fire   = in_valid & ~in_stall;
  assign s2_fire   = s2_valid_r & cmd_free;
  assign s2_valid_nxt = in_fire | (s2_valid_r & ~s2_fire);
  assign raddr     = in_code_byte[TBL_AW-1:0];

  qoisd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (new_px),
    .re    (in_fire),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign tbl_px = !rd_vld_r ? '0 : (rd_hit_r ? rd_fwd_r : ram_rdata);

  // image start wipes the state seen by its own byte
  assign cur_e   = s2_start_r ? RESET_PIXEL : cur_r;
  assign phase_e = s2_start_r ? PH_OP : phase_r;
  assign opb_e   = s2_start_r ? 8'h00 : opb_r;
  assign zp_e    = s2_start_r ? 1'b0 : zp_r;
  assign pe_e    = s2_start_r ? '0 : pe_r;
  assign done_e  = s2_start_r ? 1'b0 : done_r;
  assign slot0_e = s2_start_r ? '0 : slot0_r;

  always_comb begin
    c         = s2_byte_r;
    phase_nxt = phase_e;
    opb_nxt   = opb_e;
    zp_nxt    = zp_e;
    done_nxt  = done_e;
    act       = 1'b0;
    zflag     = 1'b0;
    wr_flag   = 1'b0;
    run_k     = 7'd0;
    base_px   = cur_e;
    if (!done_e) begin
      if (pe_e >= lim_r) begin
        done_nxt = 1'b1;
      end else begin
        act = 1'b1;
        if (zp_e) begin
          zp_nxt = 1'b0;
          if (c == BYTE_ZERO) begin
            // end marker
            done_nxt = 1'b1;
            act      = 1'b0;
          end else begin
            zflag   = 1'b1;
            base_px = slot0_e;
          end
        end
      end
    end
    r8     = base_px[31:24];
    g8     = base_px[23:16];
    b8     = base_px[15:8];
    a8     = base_px[7:0];
    vg     = {2'b00, opb_e[5:0]} + LUMA_G_BIAS;
    new_px = base_px;
    if (act) begin
      unique case (phase_e)
        PH_OP: begin
          if (c == BYTE_ZERO) begin
            zp_nxt = 1'b1;
          end else begin
            unique case (c[7:6])
              TAG_INDEX: begin
                new_px = tbl_px;
                run_k  = 7'd1;
              end
              TAG_DIFF: begin
                new_px = pack_px(r8 + {6'd0, c[5:4]} + DIFF_BIAS,
                                 g8 + {6'd0, c[3:2]} + DIFF_BIAS,
                                 b8 + {6'd0, c[1:0]} + DIFF_BIAS, a8);
                wr_flag = 1'b1;
                run_k   = 7'd1;
              end
              TAG_LUMA: begin
                opb_nxt   = c;
                phase_nxt = PH_LUMA;
              end
              TAG_RUN: begin
                if (c == OP_RGB || c == OP_RGBA) begin
                  opb_nxt   = c;
                  phase_nxt = PH_RED;
                end else begin
                  run_k = {1'b0, c[5:0]} + 7'd1;
                end
              end
              default: begin
                run_k = 7'd0;
              end
            endcase
          end
        end
        PH_LUMA: begin
          new_px = pack_px(r8 + vg + {4'd0, c[7:4]} + LUMA_RB_BIAS, g8 + vg,
                           b8 + vg + {4'd0, c[3:0]} + LUMA_RB_BIAS, a8);
          phase_nxt = PH_OP;
          wr_flag   = 1'b1;
          run_k     = 7'd1;
        end
        PH_RED: begin
          new_px    = pack_px(c, g8, b8, a8);
          phase_nxt = PH_GREEN;
        end
        PH_GREEN: begin
          new_px    = pack_px(r8, c, b8, a8);
          phase_nxt = PH_BLUE;
        end
        PH_BLUE: begin
          new_px = pack_px(r8, g8, c, a8);
          if (opb_e == OP_RGBA) begin
            phase_nxt = PH_ALPHA;
          end else begin
            phase_nxt = PH_OP;
            wr_flag   = 1'b1;
            run_k     = 7'd1;
          end
        end
        PH_ALPHA: begin
          new_px    = pack_px(r8, g8, b8, c);
          phase_nxt = PH_OP;
          wr_flag   = 1'b1;
          run_k     = 7'd1;
        end
        default: begin
          // drop the byte and resync
          phase_nxt = PH_OP;
        end
      endcase
    end
    cur_nxt = act ? new_px : cur_e;

    // clip the emission to the pixels left in the image
    zk  = {6'd0, zflag} + run_k;
    rem = lim_r - pe_e;
    hit = (zk != 7'd0) && ({{(LIM_W-7){1'b0}}, zk} >= rem);
    cnt = hit ? rem[RUN_W-1:0] : zk[RUN_W-1:0];
    if (hit) begin
      done_nxt = 1'b1;
    end
    pe_nxt = pe_e + {{(LIM_W-RUN_W){1'b0}}, cnt};
  end

  assign wr_addr = hash_px(new_px);
  assign wr_en   = s2_fire & wr_flag;

  assign slot0_nxt = (wr_en && (wr_addr == '0)) ? new_px : slot0_e;

  assign cmd_vld   = s2_fire & (cnt != '0);
  assign cmd.zflag = zflag;
  assign cmd.zpix  = slot0_e;
  assign cmd.mpix  = new_px;
  assign cmd.cnt   = cnt;
  assign cmd.hit   = hit;

  always_comb begin
    tbl_vld_nxt = tbl_vld_r;
    if (wr_en) begin
      tbl_vld_nxt[wr_addr] = 1'b1;
    end
    // clear wins over a write from the previous image
    if (in_fire && in_start_of_image) begin
      tbl_vld_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r      <= LIM_W'(1);
      s2_valid_r <= 1'b0;
      tbl_vld_r  <= '0;
      cur_r      <= RESET_PIXEL;
      phase_r    <= PH_OP;
      opb_r      <= 8'h00;
      zp_r       <= 1'b0;
      pe_r       <= '0;
      done_r     <= 1'b0;
      slot0_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lim_r <= cfg_pixel_count[LIM_W-1:0];
      end
      s2_valid_r <= s2_valid_nxt;
      tbl_vld_r  <= tbl_vld_nxt;
      if (s2_fire) begin
        cur_r   <= cur_nxt;
        phase_r <= phase_nxt;
        opb_r   <= opb_nxt;
        zp_r    <= zp_nxt;
        pe_r    <= pe_nxt;
        done_r  <= done_nxt;
        slot0_r <= slot0_nxt;
      end
    end
  end

  // capture the byte and the table read, forwarding the write of the same edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_byte_r  <= in_code_byte;
      s2_start_r <= in_start_of_image;
      rd_hit_r   <= wr_en && (wr_addr == raddr);
      rd_fwd_r   <= new_px;
      rd_vld_r   <= !in_start_of_image &&
                    (tbl_vld_r[raddr] || (wr_en && (wr_addr == raddr)));
    end
  end

  qoisd_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_vld),
    .cmd            (cmd),
    .cmd_free       (cmd_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel      (out_px),
    .out_run_last   (out_run_last),
    .out_image_last (out_image_last)
  );

  assign out_red    = out_px[31:24];
  assign out_green  = out_px[23:16];
  assign out_blue   = out_px[15:8];
  assign out_alpha  = out_px[7:0];
  assign out_rgb555 = to_rgb555(out_px);

  // a new read must always line up with the write of the byte ahead of it
  a_read_meets_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s2_valid_r) |-> s2_fire)
    else $error("byte accepted while decode stage holds");

  a_start_clears_table: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_start_of_image) |=> (tbl_vld_r == '0))
    else $error("table not empty after image start");

  a_done_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && done_e) |-> (!wr_en && !cmd_vld))
    else $error("activity after end of image");

  a_cmd_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_vld |-> cmd_free)
    else $error("command issued into a full slot");

endmodule

### sim/tb_qoi_image_stream_decoder.sv
// Testbench for qoi_image_stream_decoder: drives QOI chunk bytes, predicts each pixel
// with a cycle-free decoder in the scoreboard class, and checks every output transaction.
// Depends on qoisd_pkg and the decoder RTL only.
module tb_qoi_image_stream_decoder;
  import qoisd_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASE_BYTES    = 75;

  localparam logic [7:0]       RUN_LONGEST = {TAG_RUN, 6'd61};
  localparam logic [CFG_W-1:0] COUNT_HUGE  = 25'd16777216;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] rgb555;
    logic        run_last;
    logic        image_last;
  } qoi_pixel_t;

  class qoi_scoreboard;
    logic [31:0]       palette [TBL_DEPTH];
    logic [7:0]        cr, cg, cb, ca;
    phase_t            phase;
    logic [7:0]        opcode;
    bit                zero_held;
    longint unsigned   emitted;
    bit                done;
    logic [CFG_W-1:0]  count_limit;
    qoi_pixel_t        expected_px [$];
    int                errors;

    function new();
      count_limit = 25'd1;
      errors = 0;
      clear_image();
    endfunction

    function void clear_image();
      foreach (palette[i]) palette[i] = '0;
      {cr, cg, cb, ca} = {8'h00, 8'h00, 8'h00, ALPHA_OPAQUE};
      phase = PH_OP;
      opcode = '0;
      zero_held = 1'b0;
      emitted = 0;
      done = 1'b0;
    endfunction

    function void set_count(logic [CFG_W-1:0] value);
      count_limit = value;
    endfunction

    function int pending();
      return expected_px.size();
    endfunction

    function longint unsigned limit();
      return longint'(count_limit) & ((64'd1 << (COUNT_BITS_DEF + 1)) - 64'd1);
    endfunction

    function void store();
      int unsigned h;
      h = cr * 3 + cg * 5 + cb * 7 + ca * 11;
      palette[h[5:0]] = {cr, cg, cb, ca};
    endfunction

    function void emit();
      qoi_pixel_t px;
      logic [15:0] w;
      if (done || emitted >= limit()) begin
        done = 1'b1;
        return;
      end
      w = {1'b0, cr[7:3], cg[7:3], cb[7:3]};
      if (ca < 8'd128) w = (w & RGB555_KEEP) | RGB555_ALPHA;
      emitted++;
      px = {cr, cg, cb, ca, w, 1'b0, emitted == limit()};
      if (emitted == limit()) done = 1'b1;
      expected_px.push_back(px);
    endfunction

    function void decode(logic [7:0] code);
      logic [7:0] vg;
      case (phase)
        PH_OP: begin
          if (code == BYTE_ZERO) begin
            zero_held = 1'b1;
            return;
          end
          case (code[7:6])
            TAG_INDEX: begin
              {cr, cg, cb, ca} = palette[code[5:0]];
              emit();
            end
            TAG_DIFF: begin
              cr = cr + {6'b0, code[5:4]} + DIFF_BIAS;
              cg = cg + {6'b0, code[3:2]} + DIFF_BIAS;
              cb = cb + {6'b0, code[1:0]} + DIFF_BIAS;
              store();
              emit();
            end
            TAG_LUMA: begin
              opcode = code;
              phase = PH_LUMA;
            end
            default: begin
              if (code == OP_RGB || code == OP_RGBA) begin
                opcode = code;
                phase = PH_RED;
              end else begin
                for (int k = int'(code[5:0]) + 1; k > 0 && !done; k--) emit();
              end
            end
          endcase
        end
        PH_LUMA: begin
          vg = {2'b0, opcode[5:0]} + LUMA_G_BIAS;
          cr = cr + vg + {4'h0, code[7:4]} + LUMA_RB_BIAS;
          cg = cg + vg;
          cb = cb + vg + {4'h0, code[3:0]} + LUMA_RB_BIAS;
          phase = PH_OP;
          store();
          emit();
        end
        PH_RED: begin
          cr = code;
          phase = PH_GREEN;
        end
        PH_GREEN: begin
          cg = code;
          phase = PH_BLUE;
        end
        PH_BLUE: begin
          cb = code;
          if (opcode == OP_RGBA) begin
            phase = PH_ALPHA;
          end else begin
            phase = PH_OP;
            store();
            emit();
          end
        end
        PH_ALPHA: begin
          ca = code;
          phase = PH_OP;
          store();
          emit();
        end
        default: phase = PH_OP;
      endcase
    endfunction

    // Returns 0 when the byte is dropped without touching any state.
    function bit note_byte(logic [7:0] code, logic sof);
      int base;
      qoi_pixel_t px;
      base = expected_px.size();
      if (sof) clear_image();
      if (done) return 1'b0;
      if (emitted >= limit()) begin
        done = 1'b1;
        return 1'b1;
      end
      if (zero_held) begin
        zero_held = 1'b0;
        if (code == BYTE_ZERO) begin
          done = 1'b1;
          return 1'b1;
        end
        {cr, cg, cb, ca} = palette[0];
        emit();
      end
      if (!done) decode(code);
      if (expected_px.size() > base) begin
        px = expected_px.pop_back();
        px.run_last = 1'b1;
        expected_px.push_back(px);
      end
      return 1'b1;
    endfunction

    function void compare(string field, int unsigned want, int unsigned seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, seen);
      end
    endfunction

    function void check_pixel(qoi_pixel_t got);
      qoi_pixel_t want;
      if (expected_px.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel: expected none, actual 0x%0h", $time, got);
        return;
      end
      want = expected_px.pop_front();
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
      compare("alpha", want.alpha, got.alpha);
      compare("rgb555", want.rgb555, got.rgb555);
      compare("run_last", want.run_last, got.run_last);
      compare("image_last", want.image_last, got.image_last);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_code_byte;
  logic             in_start_of_image;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic [7:0]       out_alpha;
  logic [15:0]      out_rgb555;
  logic             out_run_last;
  logic             out_image_last;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_pixel_count;

  qoi_scoreboard sb;
  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int live_bytes = 0;

  qoi_image_stream_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_byte     (in_code_byte),
    .in_start_of_image(in_start_of_image),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_rgb555       (out_rgb555),
    .out_run_last     (out_run_last),
    .out_image_last   (out_image_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_pixel_count  (cfg_pixel_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_pixel({out_red, out_green, out_blue, out_alpha, out_rgb555,
                        out_run_last, out_image_last});
      end
    end
    out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
  end

  task automatic send_byte(input logic [7:0] code, input logic sof);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_byte <= code;
    in_start_of_image <= sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_byte(code, sof)) live_bytes++;
  endtask

  task automatic send_color(input logic [7:0] op, input logic sof, input logic [31:0] px);
    send_byte(op, sof);
    send_byte(px[31:24], 1'b0);
    send_byte(px[23:16], 1'b0);
    send_byte(px[15:8], 1'b0);
    if (op == OP_RGBA) send_byte(px[7:0], 1'b0);
  endtask

  // Drop valid, let every expected pixel out, then cover bytes still in decode.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_pixel_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_count(value);
  endtask

  task automatic directed();
    send_byte({TAG_DIFF, 6'b000000}, 1'b1);   // every channel -2
    send_byte({TAG_DIFF, 6'b111111}, 1'b0);   // every channel +1
    send_byte({TAG_LUMA, 6'b000000}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte({TAG_LUMA, 6'b111111}, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_color(OP_RGB, 1'b0, 32'h00FF8000);
    send_color(OP_RGBA, 1'b0, 32'h1234567F); // translucent: masked RGB555
    send_byte({TAG_INDEX, 6'd63}, 1'b0);
    send_byte({TAG_RUN, 6'd0}, 1'b0);
    send_byte(RUN_LONGEST, 1'b0);
    // held zero opcode, then slot 0 goes out ahead of the diff pixel
    send_byte(BYTE_ZERO, 1'b0);
    send_byte({TAG_DIFF, 6'd1}, 1'b0);
    send_byte(BYTE_ZERO, 1'b0);                // end marker
    send_byte(BYTE_ZERO, 1'b0);
    send_byte({TAG_DIFF, 6'd42}, 1'b0);        // after the end marker: dropped
  endtask

  // One chunk op, well formed most of the time; restart the image once it is over.
  task automatic send_op();
    int pick;
    logic sof;
    logic [5:0] len;
    pick = $urandom_range(99);
    sof = sb.done || ($urandom_range(99) < 3);
    if (pick < 10) begin
      send_byte(8'($urandom), sof | ($urandom_range(15) == 0));
    end else if (pick < 22) begin
      send_byte({TAG_INDEX, 6'($urandom_range(63))}, sof);
    end else if (pick < 26) begin
      send_byte(BYTE_ZERO, sof);
      send_byte(BYTE_ZERO, 1'b0);
    end else if (pick < 46) begin
      send_byte({TAG_DIFF, 6'($urandom_range(63))}, sof);
    end else if (pick < 61) begin
      send_byte({TAG_LUMA, 6'($urandom_range(63))}, sof);
      send_byte(8'($urandom), 1'b0);
    end else if (pick < 78) begin
      len = ($urandom_range(3) == 0) ? 6'($urandom_range(61)) : 6'($urandom_range(7));
      send_byte({TAG_RUN, len}, sof);
    end else if (pick < 89) begin
      send_color(OP_RGB, sof, $urandom);
    end else begin
      send_color(OP_RGBA, sof, $urandom);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [CFG_W-1:0] value,
                           input int target);
    write_count(value);
    send_idle_pct = idle;
    out_stall_pct = stall;
    live_bytes = 0;
    while (live_bytes < target) send_op();
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_code_byte <= '0;
    in_start_of_image <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_pixel_count <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_count(25'd1000);
    directed();
    // single-pixel image: the run is clipped, the next byte is dropped
    write_count(25'd1);
    send_byte({TAG_RUN, 6'd5}, 1'b1);
    send_byte({TAG_DIFF, 6'd21}, 1'b0);
    // empty image: nothing comes out
    write_count('0);
    send_byte({TAG_DIFF, 6'd21}, 1'b1);
    send_byte({TAG_INDEX, 6'd5}, 1'b0);

    run_phase(0, 0, 25'($urandom_range(200, 20)), PHASE_BYTES);
    run_phase(58, 0, COUNT_HUGE, PHASE_BYTES);
    run_phase(0, 58, '1, PHASE_BYTES);
    run_phase(21, 21, 25'($urandom_range(60, 1)), PHASE_BYTES);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("qoi_image_stream_decoder regression: pass");
    end else begin
      $display("qoi_image_stream_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("qoi_image_stream_decoder regression: fail");
    $finish;
  end

endmodule
